// ===== rtl/dtf_pkg.sv =====
// shared types and constants for the decimal text to fixed-point parser
`default_nettype none

package dtf_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MANT_W     = 59;
    localparam int unsigned PROD_W     = 63;
    localparam int unsigned NEG_W      = 60;
    localparam int unsigned SCALE_W    = 5;
    localparam int unsigned SHIFT_W    = 4;
    localparam int unsigned PACKED_W   = 64;
    localparam logic [SCALE_W-1:0] MAX_SCALE = 5'd15;

    typedef enum logic [2:0] {
        CH_DIGIT,
        CH_DOT,
        CH_MINUS,
        CH_PLUS,
        CH_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t           kind;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
        logic                 empty;
    } char_item_t;

endpackage

`default_nettype wire

// ===== rtl/dtf_front.sv =====
// front end: classifies incoming characters and holds them in a two-slot queue
`default_nettype none

module dtf_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] char_byte
    input  wire logic                   s_tlast,
    input  wire logic                   s_tuser,   // [0] empty_text
    output logic                        q_valid,
    output dtf_pkg::char_item_t         q_item,
    input  wire logic                   q_pop
);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_DOT   = 8'h2e;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [7:0] ASCII_PLUS  = 8'h2b;

    dtf_pkg::char_item_t new_item;
    dtf_pkg::char_item_t head_reg, head_next;
    dtf_pkg::char_item_t tail_reg, tail_next;
    logic [1:0]          count_reg, count_next;
    logic                push;
    logic [7:0]          digit_off;

    assign digit_off = s_tdata - ASCII_ZERO;

    always_comb begin
        new_item.digit = digit_off[dtf_pkg::DIGIT_W-1:0];
        new_item.last  = s_tlast;
        new_item.empty = s_tuser;
        if (s_tdata >= ASCII_ZERO && s_tdata <= ASCII_NINE) begin
            new_item.kind = dtf_pkg::CH_DIGIT;
        end else begin
            case (s_tdata)
                ASCII_DOT:   new_item.kind = dtf_pkg::CH_DOT;
                ASCII_MINUS: new_item.kind = dtf_pkg::CH_MINUS;
                ASCII_PLUS:  new_item.kind = dtf_pkg::CH_PLUS;
                default:     new_item.kind = dtf_pkg::CH_OTHER;
            endcase
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = head_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, q_pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    head_next = new_item;
                end else begin
                    tail_next = new_item;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = new_item;
                end else begin
                    head_next = tail_reg;
                    tail_next = new_item;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

// ===== rtl/dtf_back.sv =====
// back end: parse state, digit accumulation and the result register
`default_nettype none

module dtf_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   strict_mode,
    input  wire logic                   q_valid,
    input  wire dtf_pkg::char_item_t    q_item,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [63:0]                 m_tdata,   // [63:0] packed_value
    output logic                        m_tuser    // [0] invalid
);

    logic [dtf_pkg::MANT_W-1:0]  mag_reg, mag_next;
    logic [dtf_pkg::NEG_W-1:0]   neg_acc_reg, neg_acc_next;
    logic [dtf_pkg::SCALE_W-1:0] frac_reg, frac_next;
    logic at_start_reg, at_start_next;
    logic negative_reg, negative_next;
    logic saw_zero_reg, saw_zero_next;
    logic saw_nonzero_reg, saw_nonzero_next;
    logic lead_zero_reg, lead_zero_next;
    logic in_frac_reg, in_frac_next;
    logic stopped_reg, stopped_next;
    logic failed_reg, failed_next;
    logic prev_zero_reg, prev_zero_next;
    logic need_digit_reg, need_digit_next;
    logic mant_nz_reg, mant_nz_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [dtf_pkg::PACKED_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tuser_reg, m_tuser_next;

    logic [dtf_pkg::PROD_W-1:0] mag_ext, mag_sum;
    logic [dtf_pkg::NEG_W-1:0]  neg_sum;
    logic                       overflow;
    logic                       emits, out_free;
    logic                       is_digit;
    logic                       push_d;
    logic                       reject;
    logic [dtf_pkg::NEG_W-1:0]  result_mant;

    // times ten plus digit for the magnitude, times ten minus digit for the running negated value
    assign mag_ext  = {{(dtf_pkg::PROD_W-dtf_pkg::MANT_W){1'b0}}, mag_reg};
    assign mag_sum  = (mag_ext << 3) + (mag_ext << 1)
                    + {{(dtf_pkg::PROD_W-dtf_pkg::DIGIT_W){1'b0}}, q_item.digit};
    assign neg_sum  = (neg_acc_reg << 3) + (neg_acc_reg << 1)
                    - {{(dtf_pkg::NEG_W-dtf_pkg::DIGIT_W){1'b0}}, q_item.digit};
    assign overflow = |mag_sum[dtf_pkg::PROD_W-1:dtf_pkg::MANT_W];

    assign is_digit = (q_item.kind == dtf_pkg::CH_DIGIT);
    assign emits    = q_item.last || q_item.empty;
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = q_valid && (!emits || out_free);

    always_comb begin
        mag_next         = mag_reg;
        neg_acc_next     = neg_acc_reg;
        frac_next        = frac_reg;
        at_start_next    = at_start_reg;
        negative_next    = negative_reg;
        saw_zero_next    = saw_zero_reg;
        saw_nonzero_next = saw_nonzero_reg;
        lead_zero_next   = lead_zero_reg;
        in_frac_next     = in_frac_reg;
        stopped_next     = stopped_reg;
        failed_next      = failed_reg;
        prev_zero_next   = prev_zero_reg;
        need_digit_next  = need_digit_reg;
        mant_nz_next     = mant_nz_reg;
        push_d           = 1'b0;

        if (!failed_reg && !stopped_reg) begin
            if (at_start_reg && q_item.kind == dtf_pkg::CH_MINUS) begin
                at_start_next   = 1'b0;
                negative_next   = 1'b1;
                need_digit_next = 1'b1;
            end else if (at_start_reg && q_item.kind == dtf_pkg::CH_PLUS) begin
                at_start_next = 1'b0;
                if (strict_mode) begin
                    failed_next = 1'b1;
                end else begin
                    need_digit_next = 1'b1;
                end
            end else begin
                at_start_next   = 1'b0;
                need_digit_next = 1'b0;
                prev_zero_next  = is_digit && (q_item.digit == '0);
                if (in_frac_reg) begin
                    if (!is_digit) begin
                        stopped_next = 1'b1;
                    end else begin
                        push_d = 1'b1;
                        if (frac_reg <= dtf_pkg::MAX_SCALE) begin
                            frac_next = frac_reg + 1'b1;
                        end
                    end
                end else if (q_item.kind == dtf_pkg::CH_DOT) begin
                    in_frac_next = 1'b1;
                end else if (!is_digit) begin
                    stopped_next = 1'b1;
                end else begin
                    if (saw_zero_reg && !saw_nonzero_reg) begin
                        lead_zero_next = 1'b1;
                    end
                    if (q_item.digit == '0) begin
                        saw_zero_next = 1'b1;
                    end else begin
                        saw_nonzero_next = 1'b1;
                    end
                    push_d = 1'b1;
                end
            end
        end

        if (push_d) begin
            mag_next     = mag_sum[dtf_pkg::MANT_W-1:0];
            neg_acc_next = neg_sum;
            mant_nz_next = mant_nz_reg || (q_item.digit != '0);
            if (overflow) begin
                failed_next = 1'b1;
            end
        end

        reject = failed_next || need_digit_next || (frac_next > dtf_pkg::MAX_SCALE)
               || (strict_mode && (stopped_next || lead_zero_next
                   || (!mant_nz_next && negative_next)
                   || (in_frac_next && (frac_next == '0
                       || (!saw_zero_next && !saw_nonzero_next) || prev_zero_next))));

        result_mant = negative_next ? neg_acc_next : {1'b0, mag_next};

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (q_pop && emits) begin
            m_tvalid_next = 1'b1;
            if (q_item.empty || reject) begin
                m_tdata_next = '0;
                m_tuser_next = 1'b1;
            end else begin
                m_tdata_next = {result_mant, frac_next[dtf_pkg::SHIFT_W-1:0]};
                m_tuser_next = 1'b0;
            end
            // a finished text returns the parser to its start state
            mag_next         = '0;
            neg_acc_next     = '0;
            frac_next        = '0;
            at_start_next    = 1'b1;
            negative_next    = 1'b0;
            saw_zero_next    = 1'b0;
            saw_nonzero_next = 1'b0;
            lead_zero_next   = 1'b0;
            in_frac_next     = 1'b0;
            stopped_next     = 1'b0;
            failed_next      = 1'b0;
            prev_zero_next   = 1'b0;
            need_digit_next  = 1'b0;
            mant_nz_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg         <= '0;
            neg_acc_reg     <= '0;
            frac_reg        <= '0;
            at_start_reg    <= 1'b1;
            negative_reg    <= 1'b0;
            saw_zero_reg    <= 1'b0;
            saw_nonzero_reg <= 1'b0;
            lead_zero_reg   <= 1'b0;
            in_frac_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
            failed_reg      <= 1'b0;
            prev_zero_reg   <= 1'b0;
            need_digit_reg  <= 1'b0;
            mant_nz_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else if (q_pop) begin
            mag_reg         <= mag_next;
            neg_acc_reg     <= neg_acc_next;
            frac_reg        <= frac_next;
            at_start_reg    <= at_start_next;
            negative_reg    <= negative_next;
            saw_zero_reg    <= saw_zero_next;
            saw_nonzero_reg <= saw_nonzero_next;
            lead_zero_reg   <= lead_zero_next;
            in_frac_reg     <= in_frac_next;
            stopped_reg     <= stopped_next;
            failed_reg      <= failed_next;
            prev_zero_reg   <= prev_zero_next;
            need_digit_reg  <= need_digit_next;
            mant_nz_reg     <= mant_nz_next;
            m_tvalid_reg    <= m_tvalid_next;
        end else begin
            m_tvalid_reg    <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_parser_unit.sv =====
// top level of the decimal text to fixed-point parser
`default_nettype none

// Parses decimal text, one character word per cycle, into a 60-bit signed
// mantissa and a 4-bit decimal scale, packed as (mantissa << 4) | scale.
// The front end classifies each character and buffers it in a two-slot
// queue; the back end updates the parse state with one times-ten-plus-digit
// step per digit and loads the result register on the word flagged
// tlast (or tuser = empty text). A new word is taken every cycle as long as
// results are drained; a closing word passes through a queue slot and then
// the result register. A result held by m_tready stalls only the next
// closing word, not the words before it.
// Invalid or overflowed text gives m_tuser = 1 and m_tdata = 0.
// cfg_data sets strict syntax checking; the user must write it only while idle, the block does not enforce this.
module decimal_text_to_fixed_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,    // [0] strict_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] char_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,     // [0] empty_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,     // [63:0] packed_value
    output logic             m_tuser      // [0] invalid
);

    logic                strict_mode_reg, strict_mode_next;
    logic                q_valid;
    logic                q_pop;
    dtf_pkg::char_item_t q_item;

    assign cfg_ready        = 1'b1;
    assign strict_mode_next = (cfg_valid && cfg_ready) ? cfg_data : strict_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_mode_reg <= 1'b0;
        end else begin
            strict_mode_reg <= strict_mode_next;
        end
    end

    dtf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dtf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .strict_mode (strict_mode_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // an invalid result never carries a value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("invalid result with nonzero data");

    // an empty-text word always turns into an invalid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_item.empty |=> m_tvalid && m_tuser)
        else $error("empty text did not give an invalid result");

    // the input side only stalls while the queue holds words
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input stalled with an empty queue");

endmodule

`default_nettype wire
